>>> hw/rtl/offset_gap_filler_unit_defines.svh
// Assertion helpers used by ogf_ctrl.
`ifndef OFFSET_GAP_FILLER_UNIT_DEFINES_SVH
`define OFFSET_GAP_FILLER_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define OGF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define OGF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ogf_pkg.sv
package ogf_pkg;

  // Field widths
  localparam int OFS_W = 24;
  localparam int IVL_W = 24;
  localparam int POS_W = 32;
  localparam int FRAC_W = 8;

  // Shared adder width: holds gap * 2560 for the largest gap
  localparam int ALU_W = 36;
  // Divisor / product scratch width: holds interval * 128
  localparam int TMP_W = 31;

  // Fill bound and quotient sizing
  localparam int MAX_FILLS = 63;
  localparam int FCNT_W = 6;
  localparam int Q_W = 7;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W = 3;

  localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(6400);
  localparam logic [FCNT_W-1:0] FCNT_MAX = FCNT_W'(MAX_FILLS);
  localparam logic [Q_W-1:0] Q_CLIP_LIM = Q_W'(MAX_FILLS + 1);
  localparam logic [CNT_W-1:0] DIV_FIRST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic ge;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_CMP,
    ST_NUM,
    ST_SAT,
    ST_DIV,
    ST_FILL,
    ST_LAST
  } ogf_state_t;

endpackage

>>> hw/rtl/ogf_alu.sv
module ogf_alu
  import ogf_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic sub;
  logic [ALU_W:0] ext_b;
  logic [ALU_W:0] total;

  // Add, or subtract through the inverted operand and a carry in
  always_comb begin
    sub = (req.op == ALU_SUB);
    ext_b = sub ? {1'b1, ~req.b} : {1'b0, req.b};
    total = {1'b0, req.a} + ext_b + {{ALU_W{1'b0}}, sub};
    rsp.sum = total[ALU_W-1:0];
    // no borrow on a subtract means a >= b (unsigned)
    rsp.ge = ~total[ALU_W];
  end

endmodule

>>> hw/rtl/ogf_ctrl.sv
`include "offset_gap_filler_unit_defines.svh"

module ogf_ctrl
  import ogf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [IVL_W-1:0]        ivl,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OFS_W-1:0]        in_offset,
  input  logic                    in_first_of_set,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_is_fill,
  output logic                    out_last_of_run,
  output logic                    out_order_error,
  output logic                    out_fill_clipped,
  output alu_req_t                alu_req,
  input  alu_rsp_t                alu_rsp
);

  ogf_state_t state_r, state_nxt;

  logic [OFS_W-1:0]  cur_r, cur_nxt;
  logic              first_r, first_nxt;
  logic [OFS_W-1:0]  prev_r, prev_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [OFS_W-1:0]  gap_r, gap_nxt;
  logic [ALU_W-1:0]  acc_r, acc_nxt;
  logic [TMP_W-1:0]  tmp_r, tmp_nxt;
  logic [Q_W-2:0]    q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic              clip_r, clip_nxt;
  logic              oerr_r, oerr_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  logic              ov_r, ov_nxt;
  logic [POS_W-1:0]  opos_r, opos_nxt;
  logic              ofill_r, ofill_nxt;
  logic              olast_r, olast_nxt;
  logic              oerr_out_r, oerr_out_nxt;
  logic              oclip_r, oclip_nxt;

  logic              accept;
  logic              out_free;
  logic              gap_neg;
  logic              chk;
  logic              do_fill;
  logic [Q_W-1:0]    q_fin;
  logic              q_clip;
  logic              out_load;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign out_free = !ov_r || !out_stall;
  assign gap_neg  = alu_rsp.sum[ALU_W-1];
  assign chk      = have_prev_r && !first_r;
  assign do_fill  = chk && !gap_neg && (ivl != '0);
  assign q_fin    = {q_r, alu_rsp.ge};
  // clip only when the fills (quotient - 1) exceed the bound
  assign q_clip   = (q_fin > Q_CLIP_LIM);
  assign out_load = out_free && (state_r == ST_FILL || state_r == ST_LAST);

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_position     = opos_r;
  assign out_is_fill      = ofill_r;
  assign out_last_of_run  = olast_r;
  assign out_order_error  = oerr_out_r;
  assign out_fill_clipped = oclip_r;

  // Select operands for the shared adder
  always_comb begin
    alu_req.op = ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    unique case (state_r)
      ST_PREP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {{(ALU_W-OFS_W){cur_r[OFS_W-1]}}, cur_r};
        alu_req.b  = {{(ALU_W-OFS_W){prev_r[OFS_W-1]}}, prev_r};
      end
      ST_MUL1: begin
        // gap*256*8 + gap*256*2
        alu_req.a = {1'b0, gap_r, 11'b0};
        alu_req.b = {3'b0, gap_r, 9'b0};
      end
      ST_MUL2: begin
        alu_req.a = {8'b0, ivl, 4'b0};
        alu_req.b = {11'b0, ivl, 1'b0};
      end
      ST_MUL3: begin
        alu_req.a = {{(ALU_W-TMP_W){1'b0}}, tmp_r};
        alu_req.b = {{(ALU_W-IVL_W){1'b0}}, ivl};
      end
      ST_CMP: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {{(ALU_W-TMP_W){1'b0}}, tmp_r};
        alu_req.b  = acc_r;
      end
      ST_NUM: begin
        // 2*gap*256 + interval
        alu_req.a = {3'b0, gap_r, 9'b0};
        alu_req.b = {{(ALU_W-IVL_W){1'b0}}, ivl};
      end
      ST_SAT: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = acc_r;
        alu_req.b  = {4'b0, ivl, 8'b0};
      end
      ST_DIV: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = acc_r;
        alu_req.b  = {{(ALU_W-TMP_W){1'b0}}, tmp_r};
      end
      ST_FILL: begin
        alu_req.a = {{(ALU_W-POS_W){pos_r[POS_W-1]}}, pos_r};
        alu_req.b = {{(ALU_W-IVL_W){1'b0}}, ivl};
      end
      default: begin
        alu_req.op = ALU_ADD;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_PREP;
      ST_PREP: state_nxt = do_fill ? ST_MUL1 : ST_LAST;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_MUL3;
      ST_MUL3: state_nxt = ST_CMP;
      ST_CMP:  state_nxt = alu_rsp.ge ? ST_LAST : ST_NUM;
      ST_NUM:  state_nxt = ST_SAT;
      ST_SAT:  state_nxt = alu_rsp.ge ? ST_FILL : ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_FILL;
      ST_FILL: if (out_free && fcnt_r == FCNT_W'(1)) state_nxt = ST_LAST;
      ST_LAST: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result register updates
  always_comb begin
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    gap_nxt       = gap_r;
    acc_nxt       = acc_r;
    tmp_nxt       = tmp_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    fcnt_nxt      = fcnt_r;
    clip_nxt      = clip_r;
    oerr_nxt      = oerr_r;
    pos_nxt       = pos_r;
    ov_nxt        = ov_r && out_stall;
    opos_nxt      = opos_r;
    ofill_nxt     = ofill_r;
    olast_nxt     = olast_r;
    oerr_out_nxt  = oerr_out_r;
    oclip_nxt     = oclip_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cur_nxt   = in_offset;
          first_nxt = in_first_of_set;
          clip_nxt  = 1'b0;
          oerr_nxt  = 1'b0;
        end
      end
      ST_PREP: begin
        gap_nxt  = alu_rsp.sum[OFS_W-1:0];
        oerr_nxt = chk && gap_neg;
        pos_nxt  = {prev_r, {FRAC_W{1'b0}}};
      end
      ST_MUL1: acc_nxt = alu_rsp.sum;
      ST_MUL2: tmp_nxt = alu_rsp.sum[TMP_W-1:0];
      ST_MUL3: tmp_nxt = alu_rsp.sum[TMP_W-1:0];
      ST_CMP: begin
      end
      ST_NUM: acc_nxt = alu_rsp.sum;
      ST_SAT: begin
        if (alu_rsp.ge) begin
          // quotient is 128 or more: clip straight away
          clip_nxt = 1'b1;
          fcnt_nxt = FCNT_MAX;
        end else begin
          tmp_nxt = {ivl, {(TMP_W-IVL_W){1'b0}}};
          q_nxt   = '0;
          cnt_nxt = DIV_FIRST;
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit a cycle
        if (alu_rsp.ge) acc_nxt = alu_rsp.sum;
        q_nxt   = q_fin[Q_W-2:0];
        tmp_nxt = tmp_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          clip_nxt = q_clip;
          fcnt_nxt = q_clip ? FCNT_MAX : FCNT_W'(q_fin - Q_W'(1));
        end
      end
      ST_FILL: begin
        if (out_free) begin
          pos_nxt      = alu_rsp.sum[POS_W-1:0];
          fcnt_nxt     = fcnt_r - FCNT_W'(1);
          ov_nxt       = 1'b1;
          opos_nxt     = alu_rsp.sum[POS_W-1:0];
          ofill_nxt    = 1'b1;
          olast_nxt    = 1'b0;
          oerr_out_nxt = 1'b0;
          oclip_nxt    = clip_r;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          prev_nxt      = cur_r;
          have_prev_nxt = 1'b1;
          ov_nxt        = 1'b1;
          opos_nxt      = {cur_r, {FRAC_W{1'b0}}};
          ofill_nxt     = 1'b0;
          olast_nxt     = 1'b1;
          oerr_out_nxt  = oerr_r;
          oclip_nxt     = clip_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    first_r    <= first_nxt;
    gap_r      <= gap_nxt;
    acc_r      <= acc_nxt;
    tmp_r      <= tmp_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    fcnt_r     <= fcnt_nxt;
    clip_r     <= clip_nxt;
    oerr_r     <= oerr_nxt;
    pos_r      <= pos_nxt;
    opos_r     <= opos_nxt;
    ofill_r    <= ofill_nxt;
    olast_r    <= olast_nxt;
    oerr_out_r <= oerr_out_nxt;
    oclip_r    <= oclip_nxt;
  end

  `OGF_ASSERT_NXT(a_last_returns_idle, out_load && state_r == ST_LAST, !in_stall, "no idle")
  `OGF_ASSERT_NOW(a_fill_no_oerr, ov_r && ofill_r, !oerr_out_r && !olast_r, "fill flags")
  `OGF_ASSERT_NOW(a_fill_count_live, state_r == ST_FILL, fcnt_r != '0, "no fills left")
  `OGF_ASSERT_NXT(a_accept_leaves_idle, accept, state_r == ST_PREP, "item not started")

endmodule

>>> hw/rtl/offset_gap_filler_unit.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_stall    in_offset, in_first_of_set
// out_      output     out_valid/out_stall  out_position, out_is_fill, out_last_of_run,
//                                           out_order_error, out_fill_clipped
// cfg_      input      cfg_valid/cfg_ready  cfg_fill_interval
//
// An offset is taken only once the last one is done. No gap test for the first of
// a set, a drop or a zero interval; a gap under the threshold ends at the compare;
// else a divide counts the fills (one shared 36-bit adder, seven quotient steps,
// one fill per cycle unless out_ stalls), skipped if the fill bound is hit early.
// Reset (synchronous, rst_n low) clears the sequencer and previous offset, interval 6400.
// A stall on out_ holds the result register and pauses the fill sequence.

module offset_gap_filler_unit
  import ogf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [OFS_W-1:0] in_offset,
  input  logic                    in_first_of_set,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] out_position,
  output logic                    out_is_fill,
  output logic                    out_last_of_run,
  output logic                    out_order_error,
  output logic                    out_fill_clipped,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IVL_W-1:0]        cfg_fill_interval
);

  logic [IVL_W-1:0] ivl_r, ivl_nxt;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic [POS_W-1:0] pos_w;

  // Take configuration writes at any time
  assign cfg_ready = 1'b1;
  assign ivl_nxt   = (cfg_valid && cfg_ready) ? cfg_fill_interval : ivl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivl_r <= IVL_RESET;
    end else begin
      ivl_r <= ivl_nxt;
    end
  end

  ogf_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ogf_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .ivl              (ivl_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_offset        (in_offset),
    .in_first_of_set  (in_first_of_set),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (pos_w),
    .out_is_fill      (out_is_fill),
    .out_last_of_run  (out_last_of_run),
    .out_order_error  (out_order_error),
    .out_fill_clipped (out_fill_clipped),
    .alu_req          (alu_req),
    .alu_rsp          (alu_rsp)
  );

  assign out_position = signed'(pos_w);

endmodule

>>> bench/offset_gap_filler_unit_checker.sv
module offset_gap_filler_unit_checker
  import ogf_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [OFS_W-1:0] in_offset,
  input  logic                    in_first_of_set,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [POS_W-1:0] out_position,
  input  logic                    out_is_fill,
  input  logic                    out_last_of_run,
  input  logic                    out_order_error,
  input  logic                    out_fill_clipped,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [IVL_W-1:0]        cfg_fill_interval,
  output int                      error_count,
  output int                      pending_count
);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             is_fill;
    logic             last_of_run;
    logic             order_error;
    logic             fill_clipped;
  } position_rec_t;

  position_rec_t              expected_positions[$];
  logic [IVL_W-1:0]           interval;
  logic signed [OFS_W-1:0]    last_offset;
  logic                       have_last;

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  // Work out the positions one offset transaction produces and queue them
  task automatic predict_positions(input logic signed [OFS_W-1:0] ofs, input logic first);
    longint        cur;
    longint        prev;
    longint        ivl;
    longint        gap;
    longint        gap256;
    longint        nfill;
    logic          oerr;
    logic          clip;
    int            k;
    position_rec_t rec;
    cur   = ofs;
    prev  = last_offset;
    ivl   = interval;
    nfill = 0;
    oerr  = 1'b0;
    clip  = 1'b0;
    if (have_last && !first) begin
      gap = cur - prev;
      if (gap < 0) begin
        oerr = 1'b1;
      end else if (ivl > 0) begin
        gap256 = gap * 256;
        // gap above 1.9 intervals: fill count rounded half up
        if (gap256 * 10 > ivl * 19) begin
          nfill = (2 * gap256 + ivl) / (2 * ivl) - 1;
          if (nfill > MAX_FILLS) begin
            nfill = MAX_FILLS;
            clip  = 1'b1;
          end
        end
      end
    end
    for (k = 1; k <= nfill; k++) begin
      rec.position     = POS_W'(prev * 256 + longint'(k) * ivl);
      rec.is_fill      = 1'b1;
      rec.last_of_run  = 1'b0;
      rec.order_error  = 1'b0;
      rec.fill_clipped = clip;
      expected_positions.push_back(rec);
    end
    rec.position     = POS_W'(cur * 256);
    rec.is_fill      = 1'b0;
    rec.last_of_run  = 1'b1;
    rec.order_error  = oerr;
    rec.fill_clipped = clip;
    expected_positions.push_back(rec);
    last_offset = ofs;
    have_last   = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Track config and input transactions, compare each result transaction
  always @(posedge clk) begin
    position_rec_t want;
    if (!rst_n) begin
      interval    = IVL_RESET;
      last_offset = '0;
      have_last   = 1'b0;
      expected_positions.delete();
    end else begin
      if (in_valid && !in_stall) predict_positions(in_offset, in_first_of_set);
      if (cfg_valid && cfg_ready) interval = cfg_fill_interval;
      if (out_valid && !out_stall) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual position %h fill %b",
                   $time, out_position, out_is_fill);
          error_count++;
        end else begin
          want = expected_positions.pop_front();
          check_field("position", want.position, out_position);
          check_field("is_fill", POS_W'(want.is_fill), POS_W'(out_is_fill));
          check_field("last_of_run", POS_W'(want.last_of_run), POS_W'(out_last_of_run));
          check_field("order_error", POS_W'(want.order_error), POS_W'(out_order_error));
          check_field("fill_clipped", POS_W'(want.fill_clipped), POS_W'(out_fill_clipped));
        end
      end
    end
    pending_count = expected_positions.size();
  end

endmodule

>>> bench/offset_gap_filler_unit_tb.sv
module offset_gap_filler_unit_tb;
  import ogf_pkg::*;

  localparam int IDLE_PCT = 18;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int NUM_PHASES = 6;
  localparam longint OFS_MIN = -8388608;
  localparam longint OFS_MAX = 8388607;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [OFS_W-1:0] in_offset;
  logic                    in_first_of_set;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [POS_W-1:0] out_position;
  logic                    out_is_fill;
  logic                    out_last_of_run;
  logic                    out_order_error;
  logic                    out_fill_clipped;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [IVL_W-1:0]        cfg_fill_interval;

  int     mismatches;
  int     outstanding;
  bit     calm = 1'b0;
  longint sent_offset = 0;
  int     phase_ivl[NUM_PHASES];

  offset_gap_filler_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_offset        (in_offset),
    .in_first_of_set  (in_first_of_set),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_is_fill      (out_is_fill),
    .out_last_of_run  (out_last_of_run),
    .out_order_error  (out_order_error),
    .out_fill_clipped (out_fill_clipped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_fill_interval(cfg_fill_interval)
  );

  offset_gap_filler_unit_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_offset        (in_offset),
    .in_first_of_set  (in_first_of_set),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_is_fill      (out_is_fill),
    .out_last_of_run  (out_last_of_run),
    .out_order_error  (out_order_error),
    .out_fill_clipped (out_fill_clipped),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_fill_interval(cfg_fill_interval),
    .error_count      (mismatches),
    .pending_count    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("[offset_gap_filler_unit] ERROR");
    $finish;
  end

  // Stall the result channel at random, except during the calm stretch
  always @(negedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Send one offset transaction; valid stays high until the next call or a drain
  task automatic send_offset(input longint ofs, input logic first);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_offset       <= OFS_W'(ofs);
    in_first_of_set <= first;
    sent_offset      = ofs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every queued result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_interval(input logic [IVL_W-1:0] ivl);
    drain_results();
    cfg_valid         <= 1'b1;
    cfg_fill_interval <= ivl;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed sorted runs, with clip-sized gaps, drops and new sets mixed in
  task automatic random_offset(input longint ivl);
    int     kind;
    longint nxt;
    logic   first;
    kind  = $urandom_range(0, 99);
    first = 1'b0;
    if (kind < 70)
      nxt = sent_offset + (longint'($urandom_range(0, 40)) * ivl) / 2560 + $urandom_range(0, 3);
    else if (kind < 78)
      nxt = sent_offset + (longint'($urandom_range(60, 70)) * ivl) / 256 + $urandom_range(0, 9);
    else if (kind < 86)
      nxt = sent_offset - $urandom_range(1, 1000);
    else if (kind < 94) begin
      first = 1'b1;
      nxt   = longint'($signed(OFS_W'($urandom)));
    end else
      nxt = longint'($signed(OFS_W'($urandom)));
    if (nxt < OFS_MIN || nxt > OFS_MAX) begin
      first = 1'b1;
      nxt   = longint'($signed(OFS_W'($urandom)));
    end
    send_offset(nxt, first);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_offset         = '0;
    in_first_of_set   = 1'b0;
    cfg_valid         = 1'b0;
    cfg_fill_interval = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset interval: no previous offset, threshold edge, drops, sets, extremes
    send_offset(0, 1'b0);
    send_offset(25, 1'b0);
    send_offset(72, 1'b0);
    send_offset(121, 1'b0);
    send_offset(400, 1'b0);
    send_offset(399, 1'b0);
    send_offset(399, 1'b0);
    send_offset(5000, 1'b1);
    send_offset(OFS_MAX, 1'b0);
    send_offset(OFS_MIN, 1'b0);
    send_offset(OFS_MIN + 1000, 1'b0);
    send_offset(OFS_MIN, 1'b1);
    send_offset(OFS_MAX, 1'b0);

    // One-unit interval: exactly the fill bound, then one past it
    write_interval(IVL_W'(256));
    send_offset(0, 1'b1);
    send_offset(64, 1'b0);
    send_offset(129, 1'b0);
    send_offset(131, 1'b0);
    send_offset(132, 1'b0);

    // Two-unit interval: half-up rounding and the 1.9 threshold
    write_interval(IVL_W'(512));
    send_offset(0, 1'b1);
    send_offset(5, 1'b0);
    send_offset(8, 1'b0);
    send_offset(12, 1'b0);

    // Smallest and largest intervals
    write_interval(IVL_W'(1));
    send_offset(7, 1'b0);
    send_offset(8, 1'b0);
    write_interval({IVL_W{1'b1}});
    send_offset(0, 1'b1);
    send_offset(124518, 1'b0);
    send_offset(300000, 1'b0);

    // Random phases over several intervals
    phase_ivl[0] = 6400;
    phase_ivl[1] = 256;
    phase_ivl[2] = $urandom_range(1, 24'hFFFFFF);
    phase_ivl[3] = $urandom_range(100, 20000);
    phase_ivl[4] = 24'hFFFFFF;
    phase_ivl[5] = 1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_interval(IVL_W'(phase_ivl[p]));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        calm = (p == 3 && i >= 5 && i < 40);
        if ($urandom_range(0, 29) == 0) drain_results();
        random_offset(phase_ivl[p]);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[offset_gap_filler_unit] OK");
    end else begin
      $display("[offset_gap_filler_unit] ERROR");
    end
    $finish;
  end

endmodule
